>>> rtl/full_linear_convolution_top_assert.svh
// Assertion macros for the convolution engine checker.
`ifndef FULL_LINEAR_CONVOLUTION_TOP_ASSERT_SVH
`define FULL_LINEAR_CONVOLUTION_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FLC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FLC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/flc_pkg.sv
//------------------------------------------------------------------------------
// flc_pkg
// Types, constants and helpers shared by the convolution engine files.
//------------------------------------------------------------------------------
package flc_pkg;

  localparam int X_DEPTH = 32;
  localparam int Y_DEPTH = 32;
  localparam int LEN_CAP = 32;
  localparam int X_CAP   = (X_DEPTH < LEN_CAP) ? X_DEPTH : LEN_CAP;
  localparam int Y_CAP   = (Y_DEPTH < LEN_CAP) ? Y_DEPTH : LEN_CAP;
  localparam int X_AW    = $clog2(X_DEPTH);
  localparam int Y_AW    = $clog2(Y_DEPTH);

  localparam int OP_W    = 2;
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 32;
  localparam int LEN_W   = 6;
  localparam int RES_W   = 64;
  localparam int RIDX_W  = 6;
  localparam int CFG_IW  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_START  = 2'd2
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1
  } cfg_reg_t;

  localparam logic [LEN_W-1:0] SIZE_X_RST = 6'd10;
  localparam logic [LEN_W-1:0] SIZE_Y_RST = 6'd5;

  // Length actually used: zero means one, large values saturate to the cap.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] r,
                                                input int cap);
    logic [LEN_W-1:0] v;
    begin
      if (r == '0) begin
        v = LEN_W'(1);
      end else if (32'(r) > cap) begin
        v = LEN_W'(cap);
      end else begin
        v = r;
      end
      return v;
    end
  endfunction

endpackage

>>> rtl/full_linear_convolution_top.sv
//------------------------------------------------------------------------------
// full_linear_convolution_top
// Full linear convolution of two word sequences held in on-chip RAMs.
//------------------------------------------------------------------------------
// channel  dir  handshake            payload
// in_      in   in_valid/in_ready    in_operation, in_index, in_value
// out_     out  out_valid/out_ready  out_result, out_result_index, out_last
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A start word runs one MAC per cycle through the X/Y RAM read ports and a
// registered 32x32 multiplier while it sums the terms of result n, then drains
// the pipe and holds result n until out_ready. in_ready is low for the whole run.
// Reset is synchronous; the RAMs are not cleared. cfg_ready is always high.
//------------------------------------------------------------------------------
module full_linear_convolution_top
  import flc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  out_result,
  output logic [RIDX_W-1:0] out_result_index,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [LEN_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  logic [VAL_W-1:0] x_mem [X_DEPTH];
  logic [VAL_W-1:0] y_mem [Y_DEPTH];

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  size_x_r, size_y_r;
  logic [LEN_W-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic [RIDX_W-1:0] tot_m1_r, tot_m1_nxt;
  logic [RIDX_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0]  j_r, j_nxt;
  logic [LEN_W-1:0]  jhi;
  logic [RIDX_W-1:0] n_inc;
  logic [RIDX_W:0]   np1;
  logic [LEN_W-1:0]  jlo_next;
  logic [RIDX_W-1:0] y_off;

  logic              issue;
  logic              v1_r, first1_r, last1_r;
  logic              v2_r, first2_r, last2_r;
  logic [VAL_W-1:0]  x_q, y_q;
  logic [RES_W-1:0]  prod_r, acc_r, acc_sum;

  logic              out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]  out_result_r;
  logic [RIDX_W-1:0] out_ridx_r;
  logic              out_last_r;

  logic              in_fire, out_fire;

  function automatic logic [LEN_W-1:0] jlo_cur(input logic [RIDX_W-1:0] n,
                                                input logic [LEN_W-1:0] sy);
    logic [RIDX_W:0] p;
    begin
      p = {1'b0, n} + 1'b1;
      return (p > (RIDX_W+1)'(sy)) ? LEN_W'(p - (RIDX_W+1)'(sy)) : '0;
    end
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_result_index = out_ridx_r;
  assign out_last         = out_last_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_X_RST;
      size_y_r <= SIZE_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // RAM writes only happen in idle. Reads are not gated, but only reads made in
  // ST_MAC are used, so a used read never meets a write to the same word.
  always_ff @(posedge clk) begin
    if (in_fire && (op_t'(in_operation) == OP_LOAD_X) && (32'(in_index) < X_DEPTH)) begin
      x_mem[X_AW'(in_index)] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (op_t'(in_operation) == OP_LOAD_Y) && (32'(in_index) < Y_DEPTH)) begin
      y_mem[Y_AW'(in_index)] <= in_value;
    end
  end

  assign y_off = n_r - RIDX_W'(j_r);

  always_ff @(posedge clk) begin
    x_q <= x_mem[X_AW'(j_r)];
    y_q <= y_mem[Y_AW'(y_off)];
  end

  // term bounds for the current and the following output index
  assign jhi      = (n_r < RIDX_W'(sx_r - 1'b1)) ? LEN_W'(n_r) : (sx_r - 1'b1);
  assign n_inc    = n_r + 1'b1;
  assign np1      = {1'b0, n_inc} + 1'b1;
  assign jlo_next = (np1 > (RIDX_W+1)'(sy_r)) ? LEN_W'(np1 - (RIDX_W+1)'(sy_r)) : '0;

  assign issue = (state_r == ST_MAC);

  always_comb begin
    state_nxt     = state_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    tot_m1_nxt    = tot_m1_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (op_t'(in_operation) == OP_START)) begin
          sx_nxt     = eff_len(size_x_r, X_CAP);
          sy_nxt     = eff_len(size_y_r, Y_CAP);
          tot_m1_nxt = RIDX_W'(sx_nxt + sy_nxt - 2'd2);
          n_nxt      = '0;
          j_nxt      = '0;
          state_nxt  = ST_MAC;
        end
      end
      ST_MAC: begin
        j_nxt = j_r + 1'b1;
        if (j_r == jhi) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (v2_r && last2_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (n_r == tot_m1_r) begin
            state_nxt = ST_IDLE;
          end else begin
            n_nxt     = n_inc;
            j_nxt     = jlo_next;
            state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    tot_m1_r <= tot_m1_nxt;
    n_r      <= n_nxt;
    j_r      <= j_nxt;
  end

  // MAC pipe: RAM read, multiply, accumulate
  assign acc_sum = (first2_r ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    first1_r <= (state_r == ST_MAC) && (n_r == '0 ? j_r == '0 : j_r == jlo_cur(n_r, sy_r));
    last1_r  <= (j_r == jhi);
    first2_r <= first1_r;
    last2_r  <= last1_r;
    prod_r   <= x_q * y_q;
    if (v2_r) begin
      acc_r <= acc_sum;
    end
    if ((state_r == ST_WAIT) && v2_r && last2_r) begin
      out_result_r <= acc_sum;
      out_ridx_r   <= n_r;
      out_last_r   <= (n_r == tot_m1_r);
    end
  end

endmodule

>>> rtl/flc_checker.sv
//------------------------------------------------------------------------------
// flc_checker
// Port-level checks for the convolution engine, bound to the top level.
//------------------------------------------------------------------------------
`include "full_linear_convolution_top_assert.svh"

module flc_checker
  import flc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [OP_W-1:0]   in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [RES_W-1:0]  out_result,
  input logic [RIDX_W-1:0] out_result_index,
  input logic              out_last
);

  // a stalled result word holds
  `FLC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result) && $stable(out_result_index), "stalled result changed")

  // no input word taken while a run has results pending
  `FLC_ASSERT_IMP(a_busy_run, clk, rst_n, out_valid, !in_ready, "input taken during a run")

  // a start word blocks input in the next cycle
  `FLC_ASSERT_NXT(a_start_busy, clk, rst_n, in_valid && in_ready && (in_operation == OP_START), !in_ready && !out_valid, "start did not begin a run")

  // the flagged result ends the run
  `FLC_ASSERT_NXT(a_last_end, clk, rst_n, out_valid && out_ready && out_last, !out_valid && in_ready, "run continued after last")

endmodule

bind full_linear_convolution_top flc_checker u_flc_checker (.*);

>>> tb/tb_full_linear_convolution_top.sv
//------------------------------------------------------------------------------
// tb_full_linear_convolution_top
// Self-checking bench for the full linear convolution engine. A short table of
// directed words covers the reset lengths, operand extremes, the unused opcode
// and the length-zero case. Random phases follow: each one reprograms both
// lengths, loads unwritten entries in use and some random ones, fires starts.
// Results are checked against a predictor of the convolution sums or a table sum.
//------------------------------------------------------------------------------
module tb_full_linear_convolution_top;
  import flc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_WORDS = 270;
  localparam int N_DIR   = 30;

  localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;
  localparam logic [CFG_IW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  val;
    logic [CFG_IW-1:0] cfg_sel;
    logic [LEN_W-1:0]  cfg_val;
    logic              typed;   // single result given in sum, index 0, last set
    logic [RES_W-1:0]  sum;
  } dir_row_t;

  typedef struct packed {
    logic [RES_W-1:0]  sum;
    logic [RIDX_W-1:0] n;
    logic              last;
  } conv_out_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_WORD, OP_SPARE,  5'd31, 32'hFFFF_FFFF, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd0,  32'hFFFF_FFFF, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd1,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd2,  32'h0000_0001, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd3,  32'h8000_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd4,  32'h7FFF_FFFF, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd5,  32'hDEAD_BEEF, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd6,  32'hFFFF_FFFF, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd7,  32'h0001_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd8,  32'hCAFE_F00D, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd9,  32'hFFFF_FFFE, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_Y, 5'd0,  32'hFFFF_FFFF, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_Y, 5'd1,  32'hFFFF_FFFF, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_Y, 5'd2,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_Y, 5'd3,  32'h0000_0001, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_Y, 5'd4,  32'h1234_5678, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    // reset lengths 10 x 5
    '{ROW_WORD, OP_START,  5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_CFG,  OP_LOAD_X, 5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd1, 1'b0, 64'd0},
    '{ROW_CFG,  OP_LOAD_X, 5'd0,  32'h0000_0000, CFG_SIZE_Y, 6'd1, 1'b0, 64'd0},
    // max * max
    '{ROW_WORD, OP_START,  5'd31, 32'hFFFF_FFFF, CFG_SIZE_X, 6'd0, 1'b1,
      64'hFFFF_FFFE_0000_0001},
    // zero lengths act as one
    '{ROW_CFG,  OP_LOAD_X, 5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_CFG,  OP_LOAD_X, 5'd0,  32'h0000_0000, CFG_SIZE_Y, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_X, 5'd31, 32'h5555_5555, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_LOAD_Y, 5'd31, 32'hAAAA_AAAA, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_START,  5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b1,
      64'hFFFF_FFFE_0000_0001},
    '{ROW_WORD, OP_LOAD_X, 5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0},
    '{ROW_WORD, OP_START,  5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b1, 64'd0},
    '{ROW_CFG,  OP_LOAD_X, 5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd3, 1'b0, 64'd0},
    '{ROW_CFG,  OP_LOAD_X, 5'd0,  32'h0000_0000, CFG_SIZE_Y, 6'd2, 1'b0, 64'd0},
    '{ROW_WORD, OP_START,  5'd0,  32'h0000_0000, CFG_SIZE_X, 6'd0, 1'b0, 64'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [IDX_W-1:0]  in_index;
  logic [VAL_W-1:0]  in_value;
  logic              out_valid;
  logic              out_ready;
  logic [RES_W-1:0]  out_result;
  logic [RIDX_W-1:0] out_result_index;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [LEN_W-1:0]  cfg_data;

  // predictor state
  logic [VAL_W-1:0] x_mem [X_DEPTH];
  logic [VAL_W-1:0] y_mem [Y_DEPTH];
  bit               x_seen [X_DEPTH];
  bit               y_seen [Y_DEPTH];
  logic [LEN_W-1:0] size_x_q;
  logic [LEN_W-1:0] size_y_q;

  conv_out_t pending_sums [$];
  int        words_sent = 0;
  int        got_cnt    = 0;
  int        err_cnt    = 0;
  int        burst_left = 0;

  full_linear_convolution_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_index         (in_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result       (out_result),
    .out_result_index (out_result_index),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int used_len(input logic [LEN_W-1:0] r, input int cap);
    if (r == '0) return 1;
    if (int'(r) > cap) return cap;
    return int'(r);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)  return '0;
    if (r < 12) return LEN_W'(32);
    if (r < 17) return LEN_W'($urandom_range(33, 63));
    if (r < 20) return LEN_W'($urandom_range(9, 31));
    return LEN_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Applies one accepted word to the shadow stores; a start queues every z[n].
  task automatic conv_predict(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val);
    int               lx;
    int               ly;
    int               jlo;
    int               jhi;
    logic [RES_W-1:0] sum;
    case (op)
      OP_LOAD_X: begin
        x_mem[idx]  = val;
        x_seen[idx] = 1'b1;
      end
      OP_LOAD_Y: begin
        y_mem[idx]  = val;
        y_seen[idx] = 1'b1;
      end
      OP_START: begin
        lx = used_len(size_x_q, X_CAP);
        ly = used_len(size_y_q, Y_CAP);
        for (int n = 0; n < lx + ly - 1; n++) begin
          jlo = (n + 1 > ly) ? n + 1 - ly : 0;
          jhi = (n < lx - 1) ? n : lx - 1;
          sum = '0;
          for (int j = jlo; j <= jhi; j++) begin
            sum += RES_W'(x_mem[j]) * RES_W'(y_mem[n - j]);
          end
          pending_sums.push_back('{sum, RIDX_W'(n), (n == lx + ly - 2)});
        end
      end
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic typed,
                           input logic [RES_W-1:0] typed_sum);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid     = 1'b1;
    in_operation = op;
    in_index     = idx;
    in_value     = val;
    do @(posedge clk); while (!in_ready);
    if (typed) pending_sums.push_back('{typed_sum, RIDX_W'(0), 1'b1});
    else conv_predict(op, idx, val);
    if (op != OP_SPARE) words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_cfg(input logic [CFG_IW-1:0] sel, input logic [LEN_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (sel == CFG_SIZE_X) size_x_q = data;
    else if (sel == CFG_SIZE_Y) size_y_q = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every queued result, then let the block go idle.
  task automatic settle();
    in_valid = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  always @(posedge clk) begin
    conv_out_t want;
    if (rst_n && out_valid && out_ready) begin
      got_cnt++;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result: got sum %h n %0d last %b",
                 $time, out_result, out_result_index, out_last);
        err_cnt++;
      end else begin
        want = pending_sums.pop_front();
        if (out_result !== want.sum) begin
          $display("%0t: result: exp %h got %h", $time, want.sum, out_result);
          err_cnt++;
        end
        if (out_result_index !== want.n) begin
          $display("%0t: result_index: exp %0d got %0d", $time, want.n, out_result_index);
          err_cnt++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last: exp %b got %b", $time, want.last, out_last);
          err_cnt++;
        end
      end
    end
  end

  // Receiver: rotating stall pattern, plus one long hold-off so the block backs up.
  initial begin
    int cyc;
    int hold;
    bit held;
    cyc       = 0;
    hold      = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      cyc++;
      // start the hold-off while a word is waiting at the blocked input
      if (!held && got_cnt >= 40 && in_valid && !in_ready) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else begin
        case ((cyc / 64) % 4)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 9) < 7);
          2: out_ready = (cyc % 3 == 0);
          default: out_ready = ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  initial begin
    int               lx;
    int               ly;
    int               runs;
    int               extra;
    logic [IDX_W-1:0] idx;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_LOAD_X;
    in_index     = '0;
    in_value     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_SIZE_X;
    cfg_data     = '0;
    size_x_q     = SIZE_X_RST;
    size_y_q     = SIZE_Y_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        settle();
        write_cfg(DIR_ROWS[i].cfg_sel, DIR_ROWS[i].cfg_val);
      end else begin
        send_word(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].val,
                  DIR_ROWS[i].typed, DIR_ROWS[i].sum);
      end
    end

    while (words_sent < N_WORDS) begin
      settle();
      if ($urandom_range(0, 1)) begin
        write_cfg(CFG_SIZE_X, pick_len());
        write_cfg(CFG_SIZE_Y, pick_len());
      end else begin
        write_cfg(CFG_SIZE_Y, pick_len());
        write_cfg(CFG_SIZE_X, pick_len());
      end
      if ($urandom_range(0, 3) == 0)
        write_cfg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, LEN_W'($urandom));
      lx   = used_len(size_x_q, X_CAP);
      ly   = used_len(size_y_q, Y_CAP);
      runs = $urandom_range(1, 3);
      repeat (runs) begin
        extra = $urandom_range(0, 5);
        repeat (extra) begin
          // half the indices are drawn from the X window 0..lx-1
          idx = $urandom_range(0, 1) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, lx - 1));
          if ($urandom_range(0, 7) == 0)
            send_word(OP_SPARE, IDX_W'($urandom), $urandom, 1'b0, '0);
          else
            send_word($urandom_range(0, 1) ? OP_LOAD_Y : OP_LOAD_X, idx, rand_value(),
                      1'b0, '0);
        end
        // never read an entry that was not written
        for (int i = 0; i < lx; i++)
          if (!x_seen[i]) send_word(OP_LOAD_X, IDX_W'(i), rand_value(), 1'b0, '0);
        for (int i = 0; i < ly; i++)
          if (!y_seen[i]) send_word(OP_LOAD_Y, IDX_W'(i), rand_value(), 1'b0, '0);
        send_word(OP_START, IDX_W'($urandom), $urandom, 1'b0, '0);
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** full_linear_convolution_top: PASSED **");
    end else begin
      $display("** full_linear_convolution_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** full_linear_convolution_top: FAILED **");
    $finish;
  end

endmodule

>>> full_linear_convolution_top.f
+incdir+rtl
rtl/flc_pkg.sv
rtl/full_linear_convolution_top.sv
rtl/flc_checker.sv
tb/tb_full_linear_convolution_top.sv
